### rtl/pfr_pkg.sv
package pfr_pkg;

    // Fixed-point scaling of the chroma coefficients
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_W         = COEF_FRAC_BITS + 2;   // signed, all coefficients below 2.0
    localparam int PROD_W         = COEF_FRAC_BITS + 11;  // coefficient times signed 9-bit chroma
    localparam int SUM_W          = COEF_FRAC_BITS + 11;  // luma plus chroma terms
    localparam int QUOT_W         = SUM_W - COEF_FRAC_BITS;

    // Coefficients rounded to nearest, halves up
    localparam logic [63:0] RV_RAW = ((64'd14075 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam logic [63:0] GU_RAW = ((64'd3455  << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam logic [63:0] GV_RAW = ((64'd7169  << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam logic [63:0] BU_RAW = ((64'd17790 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;

    localparam logic signed [COEF_W-1:0] K_RV = $signed({1'b0, RV_RAW[COEF_W-2:0]});
    localparam logic signed [COEF_W-1:0] K_GU = $signed({1'b0, GU_RAW[COEF_W-2:0]});
    localparam logic signed [COEF_W-1:0] K_GV = $signed({1'b0, GV_RAW[COEF_W-2:0]});
    localparam logic signed [COEF_W-1:0] K_BU = $signed({1'b0, BU_RAW[COEF_W-2:0]});

    // Source formats
    localparam logic [2:0] FMT_RGBA = 3'd0;
    localparam logic [2:0] FMT_RGB  = 3'd1;
    localparam logic [2:0] FMT_BGR  = 3'd2;
    localparam logic [2:0] FMT_BGRA = 3'd3;
    localparam logic [2:0] FMT_LUM  = 3'd4;
    localparam logic [2:0] FMT_UYVY = 3'd5;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last_in_run;
    } t_pix_out;

    // Classified transaction passed from the front end to the back end
    typedef struct packed {
        logic [2:0]               fmt;
        t_pix_in                  pix;
        logic signed [PROD_W-1:0] r_term;
        logic signed [PROD_W-1:0] g_term;
        logic signed [PROD_W-1:0] b_term;
    } t_work;

endpackage

### rtl/pixel_format_to_rgba_core.sv
// Pixel format to RGBA converter. Each input transaction carries four source
// bytes; the pixel_format register (written through i_cfg_we / i_cfg_data;
// the user must write it only while the block is idle, the block itself does
// not enforce this) selects how they are read: rgba, rgb, bgr, bgra,
// luminance or uyvy. Plain formats give one RGBA pixel per transaction with
// last_in_run set; uyvy gives two pixels sharing one chroma pair, the Y0
// pixel first and the Y1 pixel second with last_in_run set. Undefined format
// codes pass the four bytes through unchanged. Throughput is one output pixel
// per clock while the receiver is ready, set by the back-end output register.
// From input acceptance to the first pixel a transaction passes the front-end
// register (format capture and chroma multiplies), a two-entry queue, and the
// back-end output register. Both sides stall independently.
module pixel_format_to_rgba_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  pfr_pkg::t_pix_in  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output pfr_pkg::t_pix_out o_data
);

    logic           push;
    logic           push_ready;
    pfr_pkg::t_work front_work;
    logic           q_valid;
    logic           q_pop;
    pfr_pkg::t_work q_work;

    // Front end: capture the format with the transaction, form chroma products
    pfr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data       (i_data),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_work       (front_work)
    );

    // Short queue: decouple front-end stalls from output back-pressure
    pfr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_work       (front_work),
        .o_valid      (q_valid),
        .i_pop        (q_pop),
        .o_work       (q_work)
    );

    // Back end: reorder bytes or finish the YUV sums, one pixel per cycle while the receiver is ready
    pfr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (q_valid),
        .i_work       (q_work),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_data       (o_data)
    );

endmodule

### rtl/pfr_front.sv
module pfr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_data,
    input  logic           i_valid,
    output logic           o_ready,
    input  pfr_pkg::t_pix_in i_data,
    output logic           o_push,
    input  logic           i_push_ready,
    output pfr_pkg::t_work o_work
);

    logic [2:0]     r_fmt;
    logic           r_valid;
    logic           n_valid;
    pfr_pkg::t_work r_work;
    pfr_pkg::t_work n_work;

    logic signed [8:0]                  du;
    logic signed [8:0]                  dv;
    logic signed [pfr_pkg::PROD_W-1:0]  gu_prod;
    logic signed [pfr_pkg::PROD_W-1:0]  gv_prod;

    assign o_ready = !r_valid || i_push_ready;
    assign o_push  = r_valid;
    assign o_work  = r_work;

    // Signed chroma, value minus 128
    assign du = $signed({1'b0, i_data.byte0}) - 9'sd128;
    assign dv = $signed({1'b0, i_data.byte2}) - 9'sd128;

    assign gu_prod = pfr_pkg::PROD_W'(pfr_pkg::K_GU * du);
    assign gv_prod = pfr_pkg::PROD_W'(pfr_pkg::K_GV * dv);

    always_comb begin
        n_work.fmt    = r_fmt;
        n_work.pix    = i_data;
        n_work.r_term = pfr_pkg::PROD_W'(pfr_pkg::K_RV * dv);
        n_work.g_term = gu_prod + gv_prod;
        n_work.b_term = pfr_pkg::PROD_W'(pfr_pkg::K_BU * du);
    end

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_push_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt   <= pfr_pkg::FMT_RGBA;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_fmt <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_work <= n_work;
        end
    end

endmodule

### rtl/pfr_queue.sv
module pfr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_push_ready,
    input  pfr_pkg::t_work i_work,
    output logic           o_valid,
    input  logic           i_pop,
    output pfr_pkg::t_work o_work
);

    localparam int PTR_W = (pfr_pkg::QUEUE_DEPTH > 1) ? $clog2(pfr_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(pfr_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(pfr_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(pfr_pkg::QUEUE_DEPTH);

    pfr_pkg::t_work     r_mem [pfr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_valid      = (r_count != '0);
    assign o_work       = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

endmodule

### rtl/pfr_back.sv
module pfr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_work_valid,
    input  pfr_pkg::t_work   i_work,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output pfr_pkg::t_pix_out o_data
);

    logic              r_second;
    logic              r_valid;
    pfr_pkg::t_pix_out r_out;
    pfr_pkg::t_pix_out n_out;
    logic              load;
    logic              is_uyvy;

    logic [7:0]                        y_sel;
    logic signed [pfr_pkg::SUM_W-1:0]  ys;
    logic signed [pfr_pkg::SUM_W-1:0]  r_sum;
    logic signed [pfr_pkg::SUM_W-1:0]  g_sum;
    logic signed [pfr_pkg::SUM_W-1:0]  b_sum;

    function automatic logic [7:0] floor_clamp(input logic signed [pfr_pkg::SUM_W-1:0] v);
        logic signed [pfr_pkg::SUM_W-1:0]  sh;
        logic signed [pfr_pkg::QUOT_W-1:0] q;
        sh = v >>> pfr_pkg::COEF_FRAC_BITS;
        q  = sh[pfr_pkg::QUOT_W-1:0];
        if (q < 0) begin
            floor_clamp = 8'd0;
        end else if (q > $signed(pfr_pkg::QUOT_W'(255))) begin
            floor_clamp = 8'd255;
        end else begin
            floor_clamp = q[7:0];
        end
    endfunction

    assign is_uyvy = (i_work.fmt == pfr_pkg::FMT_UYVY);
    assign load    = i_work_valid && (!r_valid || i_ready);
    assign o_pop   = load && (!is_uyvy || r_second);
    assign o_valid = r_valid;
    assign o_data  = r_out;

    assign y_sel = r_second ? i_work.pix.byte3 : i_work.pix.byte1;
    assign ys    = $signed({{(pfr_pkg::SUM_W - 8 - pfr_pkg::COEF_FRAC_BITS){1'b0}}, y_sel,
                            {pfr_pkg::COEF_FRAC_BITS{1'b0}}});
    assign r_sum = ys + pfr_pkg::SUM_W'(i_work.r_term);
    assign g_sum = ys - pfr_pkg::SUM_W'(i_work.g_term);
    assign b_sum = ys + pfr_pkg::SUM_W'(i_work.b_term);

    always_comb begin
        n_out.red         = i_work.pix.byte0;
        n_out.green       = i_work.pix.byte1;
        n_out.blue        = i_work.pix.byte2;
        n_out.alpha       = i_work.pix.byte3;
        n_out.last_in_run = 1'b1;
        case (i_work.fmt)
            pfr_pkg::FMT_RGB: begin
                n_out.alpha = 8'hFF;
            end
            pfr_pkg::FMT_BGR: begin
                n_out.red   = i_work.pix.byte2;
                n_out.blue  = i_work.pix.byte0;
                n_out.alpha = 8'hFF;
            end
            pfr_pkg::FMT_BGRA: begin
                n_out.red  = i_work.pix.byte2;
                n_out.blue = i_work.pix.byte0;
            end
            pfr_pkg::FMT_LUM: begin
                n_out.green = i_work.pix.byte0;
                n_out.blue  = i_work.pix.byte0;
                n_out.alpha = 8'hFF;
            end
            pfr_pkg::FMT_UYVY: begin
                n_out.red         = floor_clamp(r_sum);
                n_out.green       = floor_clamp(g_sum);
                n_out.blue        = floor_clamp(b_sum);
                n_out.alpha       = 8'hFF;
                n_out.last_in_run = r_second;
            end
            default: begin
                // rgba and unknown codes pass straight through
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (load && is_uyvy) begin
                r_second <= !r_second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

endmodule

### dv/pixel_format_to_rgba_core_tb.sv
`timescale 1ns / 1ps

module pixel_format_to_rgba_core_tb;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 6;
    localparam int IDLE_PCT        = 23;        // chance per cycle that a side idles
    localparam int HOLD_OFF_CYCLES = 80;        // long receiver stall, fills the pipeline
    localparam int DRAIN_SLACK     = 8;         // comfortably beyond the pipeline latency
    localparam int TIMEOUT_NS      = 2_000_000;

    // Format codes the block treats as plain pass-through
    localparam logic [2:0] FMT_RSVD6 = 3'd6;
    localparam logic [2:0] FMT_RSVD7 = 3'd7;

    // Random phases: uyvy gets the largest share, both ends of the code range appear
    localparam int NUM_PHASES  = 12;
    localparam int CALM_PHASE  = 2;             // neither side idles
    localparam int HOLD_PHASE  = 4;             // receiver holds off while the sender pushes
    localparam int PAUSE_PHASE = 7;             // sender waits for a full drain mid-phase
    localparam logic [2:0] PHASE_FMT [NUM_PHASES] = '{
        pfr_pkg::FMT_UYVY, pfr_pkg::FMT_RGB, pfr_pkg::FMT_UYVY, pfr_pkg::FMT_BGRA,
        pfr_pkg::FMT_UYVY, pfr_pkg::FMT_LUM, FMT_RSVD7, pfr_pkg::FMT_UYVY,
        pfr_pkg::FMT_BGR, pfr_pkg::FMT_RGBA, FMT_RSVD6, pfr_pkg::FMT_UYVY
    };

    // Chroma coefficients in Q(FRAC), rounded to nearest with halves up
    localparam int    FRAC  = pfr_pkg::COEF_FRAC_BITS;
    localparam longint CK_RV = ((longint'(14075) << FRAC) + 5000) / 10000;
    localparam longint CK_GU = ((longint'(3455)  << FRAC) + 5000) / 10000;
    localparam longint CK_GV = ((longint'(7169)  << FRAC) + 5000) / 10000;
    localparam longint CK_BU = ((longint'(17790) << FRAC) + 5000) / 10000;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_cfg_we   = 1'b0;
    logic [2:0]        i_cfg_data = '0;
    logic              i_valid    = 1'b0;
    logic              o_ready;
    pfr_pkg::t_pix_in  i_data     = '0;
    logic              o_valid;
    logic              i_ready    = 1'b0;
    pfr_pkg::t_pix_out o_data;

    pixel_format_to_rgba_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

    pfr_pkg::t_pix_in  pix_backlog [$];    // source pixels waiting to be offered
    pfr_pkg::t_pix_out pixels_due [$];     // RGBA pixels the block still owes, oldest first
    pfr_pkg::t_pix_out due_px;
    logic [2:0] fmt_shadow    = pfr_pkg::FMT_RGBA;
    bit         in_taken      = 1'b0;
    bit         calm          = 1'b0;
    bit         stall_request = 1'b0;
    int         stall_left    = 0;
    int         fail_count    = 0;

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hold reset for a fixed count, then release it once for good
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic pfr_pkg::t_pix_out make_pixel(logic [7:0] r, logic [7:0] g,
                                                     logic [7:0] b, logic [7:0] a,
                                                     logic last);
        pfr_pkg::t_pix_out px;
        px.red         = r;
        px.green       = g;
        px.blue        = b;
        px.alpha       = a;
        px.last_in_run = last;
        return px;
    endfunction

    // Drop the fraction bits rounding towards minus infinity, then clamp to a byte
    function automatic logic [7:0] floor_clamp8(longint acc);
        longint q;
        q = acc >>> FRAC;
        if (q < 0) return 8'd0;
        if (q > 255) return 8'd255;
        return q[7:0];
    endfunction

    function automatic pfr_pkg::t_pix_out yuv_pixel(logic [7:0] y, longint du, longint dv,
                                                    logic last);
        longint ys;
        ys = longint'(y) << FRAC;
        return make_pixel(floor_clamp8(ys + CK_RV * dv),
                          floor_clamp8(ys - CK_GU * du - CK_GV * dv),
                          floor_clamp8(ys + CK_BU * du),
                          8'hFF, last);
    endfunction

    // Work out the RGBA pixels one source transaction produces under the current format
    task automatic predict_pixels(input pfr_pkg::t_pix_in p);
        longint du;
        longint dv;
        case (fmt_shadow)
            pfr_pkg::FMT_RGB:
                pixels_due.push_back(make_pixel(p.byte0, p.byte1, p.byte2, 8'hFF, 1'b1));
            pfr_pkg::FMT_BGR:
                pixels_due.push_back(make_pixel(p.byte2, p.byte1, p.byte0, 8'hFF, 1'b1));
            pfr_pkg::FMT_BGRA:
                pixels_due.push_back(make_pixel(p.byte2, p.byte1, p.byte0, p.byte3, 1'b1));
            pfr_pkg::FMT_LUM:
                pixels_due.push_back(make_pixel(p.byte0, p.byte0, p.byte0, 8'hFF, 1'b1));
            pfr_pkg::FMT_UYVY: begin
                // Both pixels share one chroma pair; the Y1 pixel closes the run
                du = longint'(p.byte0) - 128;
                dv = longint'(p.byte2) - 128;
                pixels_due.push_back(yuv_pixel(p.byte1, du, dv, 1'b0));
                pixels_due.push_back(yuv_pixel(p.byte3, du, dv, 1'b1));
            end
            // rgba and the two undefined codes pass all four bytes straight through
            default:
                pixels_due.push_back(make_pixel(p.byte0, p.byte1, p.byte2, p.byte3, 1'b1));
        endcase
    endtask

    // Lean towards the byte extremes and neutral chroma, otherwise anything goes
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'($urandom_range(136, 120));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic queue_pixel(input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2, input logic [7:0] b3);
        pix_backlog.push_back(pfr_pkg::t_pix_in'{b0, b1, b2, b3});
    endtask

    // Hold until every queued transaction is in and every owed pixel is out
    task automatic wait_until_drained();
        while (pix_backlog.size() != 0 || i_valid || pixels_due.size() != 0)
            @(negedge i_clk);
    endtask

    // Write the format register only once the block has gone quiet
    task automatic load_format(input logic [2:0] fmt);
        wait_until_drained();
        repeat (DRAIN_SLACK) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= fmt;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        fmt_shadow  = fmt;
    endtask

    // Input side: note each accepted transaction and predict its pixels
    always @(posedge i_clk) begin
        in_taken = i_rst_n && i_valid && o_ready;
        if (in_taken) predict_pixels(i_data);
    end

    // Driver: advance to the next source pixel only once the current one has gone in
    always @(negedge i_clk) begin
        if (!i_valid || in_taken) begin
            if (i_rst_n && pix_backlog.size() != 0 &&
                (calm || $urandom_range(99) >= IDLE_PCT)) begin
                i_data  <= pix_backlog.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (stall_request) begin
            stall_request = 1'b0;
            stall_left    = HOLD_OFF_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: compare every accepted pixel against the oldest one owed
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pixels_due.size() == 0) begin
                $error("pixel with none owed: %h", o_data);
                fail_count++;
            end else begin
                due_px = pixels_due.pop_front();
                if (o_data.red !== due_px.red) begin
                    $error("red: expected %0d, got %0d", due_px.red, o_data.red);
                    fail_count++;
                end
                if (o_data.green !== due_px.green) begin
                    $error("green: expected %0d, got %0d", due_px.green, o_data.green);
                    fail_count++;
                end
                if (o_data.blue !== due_px.blue) begin
                    $error("blue: expected %0d, got %0d", due_px.blue, o_data.blue);
                    fail_count++;
                end
                if (o_data.alpha !== due_px.alpha) begin
                    $error("alpha: expected %0d, got %0d", due_px.alpha, o_data.alpha);
                    fail_count++;
                end
                if (o_data.last_in_run !== due_px.last_in_run) begin
                    $error("last_in_run: expected %0d, got %0d",
                           due_px.last_in_run, o_data.last_in_run);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int n_items;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;

        wait (i_rst_n === 1'b1);
        @(negedge i_clk);

        // Directed: run first under the reset format, rgba
        queue_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_pixel(8'h12, 8'h34, 8'h56, 8'h78);

        load_format(pfr_pkg::FMT_RGB);
        queue_pixel(8'hFF, 8'h00, 8'hAA, 8'h00);
        queue_pixel(8'h00, 8'hFF, 8'h55, 8'hFF);

        load_format(pfr_pkg::FMT_BGR);
        queue_pixel(8'h01, 8'h80, 8'hFE, 8'h00);
        queue_pixel(8'hAA, 8'h55, 8'h00, 8'hFF);

        load_format(pfr_pkg::FMT_BGRA);
        queue_pixel(8'hFF, 8'h00, 8'h00, 8'h7F);
        queue_pixel(8'h00, 8'hFF, 8'hFF, 8'h00);

        load_format(pfr_pkg::FMT_LUM);
        queue_pixel(8'h00, 8'hFF, 8'hFF, 8'hFF);
        queue_pixel(8'hFF, 8'h00, 8'h00, 8'h00);

        // uyvy: neutral chroma, full swings that clamp at both ends, broadcast range
        load_format(pfr_pkg::FMT_UYVY);
        queue_pixel(8'd128, 8'd0,   8'd128, 8'd255);
        queue_pixel(8'd0,   8'd255, 8'd0,   8'd0);
        queue_pixel(8'd255, 8'd0,   8'd255, 8'd255);
        queue_pixel(8'd0,   8'd128, 8'd255, 8'd128);
        queue_pixel(8'd255, 8'd128, 8'd0,   8'd128);
        queue_pixel(8'd128, 8'd16,  8'd128, 8'd235);

        // Undefined codes behave as a plain pass-through
        load_format(FMT_RSVD6);
        queue_pixel(8'h5A, 8'hA5, 8'h3C, 8'hC3);
        load_format(FMT_RSVD7);
        queue_pixel(8'hC3, 8'h3C, 8'hA5, 8'h5A);

        // Random phases, each under its own format
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            load_format(PHASE_FMT[ph]);
            calm    = (ph == CALM_PHASE);
            n_items = $urandom_range(48, 36);
            for (int k = 0; k < n_items; k++) begin
                if (ph == PAUSE_PHASE && k == n_items / 2) wait_until_drained();
                b0 = rand_byte();
                b1 = rand_byte();
                b2 = rand_byte();
                b3 = rand_byte();
                queue_pixel(b0, b1, b2, b3);
                // Stall the receiver while the sender still has plenty to offer
                if (ph == HOLD_PHASE && k == 8) stall_request = 1'b1;
            end
        end

        wait_until_drained();
        repeat (DRAIN_SLACK) @(negedge i_clk);

        if (fail_count == 0 && pixels_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
